>>> rtl/core/assert_macros.svh
// Assertion macros used by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NR(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define ASSERT_AT(lbl, ck, rstn, prop, msg)
`define ASSERT_NR(lbl, ck, prop, msg)
`endif
`endif

>>> rtl/core/dicc_pkg.sv
// Shared constants and types of the dictionary index coverage check.
package dicc_pkg;

  localparam int DICT_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(DICT_DEPTH);
  localparam int IDX_W      = 10;
  localparam int LEN_W      = 11;
  localparam int EPOCH_W    = 8;
  localparam int PADDR_W    = 2;
  localparam int PDATA_W    = 32;

  localparam logic [LEN_W-1:0]   COUNT_MAX   = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_ZERO  = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [ADDR_W-1:0]  CLR_LAST    = ADDR_W'(DICT_DEPTH - 1);

  localparam logic [PADDR_W-1:0] ADDR_DICT_LENGTH = PADDR_W'(0);

  typedef logic [EPOCH_W-1:0] epoch_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    epoch_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

>>> rtl/core/dicc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dicc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/dicc_cfg.sv
// APB register file holding the dictionary length.
module dicc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dicc_pkg::PADDR_W-1:0]  paddr,
  input  logic [dicc_pkg::PDATA_W-1:0]  pwdata,
  output logic [dicc_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [dicc_pkg::LEN_W-1:0]    dict_len
);
  import dicc_pkg::*;

  logic [LEN_W-1:0] dict_len_r;
  logic [LEN_W-1:0] dict_len_nxt;
  logic             wr_en;

  always_comb begin
    wr_en        = psel && penable && pwrite && (paddr == ADDR_DICT_LENGTH);
    dict_len_nxt = wr_en ? pwdata[LEN_W-1:0] : dict_len_r;
    prdata       = (paddr == ADDR_DICT_LENGTH) ? PDATA_W'(dict_len_r) : '0;
    pready       = 1'b1;
    dict_len     = dict_len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dict_len_r <= '0;
    end else begin
      dict_len_r <= dict_len_nxt;
    end
  end

endmodule

>>> rtl/core/dicc_track.sv
// Seen-map tracking: input register, epoch compare, forward, clear sweep, counters and result register.
`include "assert_macros.svh"
module dicc_track (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dicc_pkg::IDX_W-1:0] in_index,
  input  logic                       in_is_null,
  input  logic                       in_last,
  input  logic [dicc_pkg::LEN_W-1:0] dict_len,
  output logic                       busy,
  output dicc_pkg::ram_req_t         ram_req,
  input  dicc_pkg::epoch_t           ram_rdata,
  output logic                       out_strobe,
  output logic                       out_all_used,
  output logic                       out_index_error,
  output logic [dicc_pkg::LEN_W-1:0] out_distinct_seen
);
  import dicc_pkg::*;

  logic              s1_vld_r, s1_vld_nxt;
  logic [IDX_W-1:0]  s1_idx_r;
  logic              s1_null_r;
  logic              s1_last_r;
  epoch_t            cur_r, cur_nxt;
  logic              clr_act_r, clr_act_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              fw_vld_r, fw_vld_nxt;
  logic [IDX_W-1:0]  fw_idx_r;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic              flt_r, flt_nxt;
  logic              ostb_r, ostb_nxt;
  logic              oall_r;
  logic              oerr_r;
  logic [LEN_W-1:0]  ocnt_r;

  logic             accept;
  logic             wrap_hold;
  logic             in_rng;
  logic             hit;
  logic             is_new;
  logic [LEN_W-1:0] cnt_inc;
  logic             flt_upd;

  always_comb begin
    accept    = start && !busy;
    wrap_hold = s1_vld_r && s1_last_r && (cur_r == EPOCH_MAX);
    busy      = clr_act_r || wrap_hold;

    in_rng  = !s1_null_r && (LEN_W'(s1_idx_r) < dict_len) && (32'(s1_idx_r) < DICT_DEPTH);
    hit     = (ram_rdata == cur_r) || (fw_vld_r && (fw_idx_r == s1_idx_r));
    is_new  = in_rng && !hit;
    cnt_inc = cnt_r + LEN_W'(is_new && (cnt_r != COUNT_MAX));
    flt_upd = flt_r || (!s1_null_r && !in_rng);

    ram_req.raddr = ADDR_W'(in_index);
    if (clr_act_r) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = clr_addr_r;
      ram_req.wdata = EPOCH_ZERO;
    end else begin
      ram_req.we    = s1_vld_r && in_rng;
      ram_req.waddr = ADDR_W'(s1_idx_r);
      ram_req.wdata = cur_r;
    end

    s1_vld_nxt   = accept;
    cur_nxt      = cur_r;
    clr_act_nxt  = clr_act_r;
    clr_addr_nxt = clr_addr_r;
    fw_vld_nxt   = s1_vld_r && in_rng && !s1_last_r;
    cnt_nxt      = cnt_r;
    flt_nxt      = flt_r;
    ostb_nxt     = s1_vld_r && s1_last_r;

    if (clr_act_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == CLR_LAST) begin
        clr_act_nxt = 1'b0;
        cur_nxt     = EPOCH_FIRST;
      end
    end

    if (s1_vld_r) begin
      if (s1_last_r) begin
        cnt_nxt = '0;
        flt_nxt = 1'b0;
        if (cur_r == EPOCH_MAX) begin
          clr_act_nxt  = 1'b1;
          clr_addr_nxt = '0;
        end else begin
          cur_nxt = cur_r + EPOCH_FIRST;
        end
      end else begin
        cnt_nxt = cnt_inc;
        flt_nxt = flt_upd;
      end
    end

    out_strobe        = ostb_r;
    out_all_used      = oall_r;
    out_index_error   = oerr_r;
    out_distinct_seen = ocnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      cur_r      <= EPOCH_FIRST;
      clr_act_r  <= 1'b1;
      clr_addr_r <= '0;
      fw_vld_r   <= 1'b0;
      cnt_r      <= '0;
      flt_r      <= 1'b0;
      ostb_r     <= 1'b0;
    end else begin
      s1_vld_r   <= s1_vld_nxt;
      cur_r      <= cur_nxt;
      clr_act_r  <= clr_act_nxt;
      clr_addr_r <= clr_addr_nxt;
      fw_vld_r   <= fw_vld_nxt;
      cnt_r      <= cnt_nxt;
      flt_r      <= flt_nxt;
      ostb_r     <= ostb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx_r  <= in_index;
      s1_null_r <= in_is_null;
      s1_last_r <= in_last;
    end
    fw_idx_r <= s1_idx_r;
    if (s1_vld_r && s1_last_r) begin
      oall_r <= !flt_upd && (cnt_inc == dict_len);
      oerr_r <= flt_upd;
      ocnt_r <= cnt_inc;
    end
  end

  `ASSERT_AT(a_clear_no_item, clk, rst_n, clr_act_r |-> !s1_vld_r, "item in flight during clear")
  `ASSERT_AT(a_epoch_nonzero, clk, rst_n, cur_r != EPOCH_ZERO, "epoch equals cleared mark")
  `ASSERT_AT(a_strobe_src, clk, rst_n, ostb_r |-> $past(s1_vld_r && s1_last_r), "stray result")
  `ASSERT_AT(a_wrap_clear, clk, rst_n, wrap_hold |=> clr_act_r, "epoch wrap without clear")

endmodule

>>> rtl/core/dictionary_index_coverage_check_core.sv
// Top level of the dictionary index coverage check.
// Takes one index entry per cycle (start while busy is low) and gives one result beat,
// marked by out_strobe, after the entry with last passes the input and result registers.
// Each entry reads a 1024-entry epoch-tagged seen map and in-range entries write it back;
// a one-entry forward covers back-to-back repeats of an index. After reset busy stays high
// while the map is swept; after every 255th column, as the epoch tag wraps, it is high for
// the final entry and then the same sweep. Results cannot be stalled.
module dictionary_index_coverage_check_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [dicc_pkg::IDX_W-1:0]   in_index,
  input  logic                         in_is_null,
  input  logic                         in_last,
  output logic                         out_strobe,
  output logic                         out_all_used,
  output logic                         out_index_error,
  output logic [dicc_pkg::LEN_W-1:0]   out_distinct_seen,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dicc_pkg::PADDR_W-1:0] paddr,
  input  logic [dicc_pkg::PDATA_W-1:0] pwdata,
  output logic [dicc_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import dicc_pkg::*;

  logic [LEN_W-1:0] dict_len;
  ram_req_t         ram_req;
  epoch_t           ram_rdata;

  dicc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .dict_len (dict_len)
  );

  dicc_track u_track (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .in_index          (in_index),
    .in_is_null        (in_is_null),
    .in_last           (in_last),
    .dict_len          (dict_len),
    .busy              (busy),
    .ram_req           (ram_req),
    .ram_rdata         (ram_rdata),
    .out_strobe        (out_strobe),
    .out_all_used      (out_all_used),
    .out_index_error   (out_index_error),
    .out_distinct_seen (out_distinct_seen)
  );

  dicc_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (DICT_DEPTH)
  ) u_seen_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule
